// File: hw/rtl/tbcd_pkg.sv
package tbcd_pkg;

  localparam int unsigned BUFFER_DEPTH_DEF = 64;

  // field widths
  localparam int unsigned CLK_W   = 23;
  localparam int unsigned VALUE_W = 24;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned TOTAL_W = 32;

  localparam logic [CLK_W-1:0] CLOCK_BASE_RST = 23'd2500000;
  localparam int unsigned CLOCK_STEP_HZ = 100000;
  localparam int unsigned PCT_BASE      = 50;
  localparam int unsigned PCT_STEP      = 10;

  // action codes
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_POLL = 1'b1;

  // control byte codes
  localparam logic [7:0] CMD_STOP  = 8'h80;
  localparam logic [7:0] CMD_FLUSH = 8'h81;
  localparam logic [7:0] CMD_RESET = 8'hFF;
  localparam logic [7:0] CMD_ECHO  = 8'hC0;
  localparam logic [3:0] GRP_STOP  = 4'h8;
  localparam logic [3:0] GRP_PITCH = 4'h9;
  localparam logic [3:0] GRP_SPEED = 4'hA;
  localparam logic [3:0] GRP_CLOCK = 4'hB;
  localparam logic [3:0] GRP_ECHO  = 4'hC;
  localparam logic [3:0] GRP_ENG   = 4'hD;
  localparam logic [3:0] GRP_RESET = 4'hF;

  // text byte codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_QUEST = 8'h3F;

  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_STOP  = 3'd1,
    KIND_RESET = 3'd2,
    KIND_PITCH = 3'd3,
    KIND_SPEED = 3'd4,
    KIND_CLOCK = 3'd5,
    KIND_CHAR  = 3'd6
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [VALUE_W-1:0] value;
    logic               is_cmd;
    logic               set_flush;
    logic               clr_buf;
    logic               tog_echo;
    logic               eng_wr;
    logic               eng_val;
    logic               store;
  } dec_t;

endpackage

// File: hw/rtl/tbcd_store.sv
module tbcd_store #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/tbcd_decode.sv
module tbcd_decode (
  input  logic [7:0]               byte_i,
  input  logic [tbcd_pkg::CLK_W-1:0] clock_base_i,
  output tbcd_pkg::dec_t           dec_o
);
  import tbcd_pkg::*;

  logic [3:0] nib;
  logic [VALUE_W-1:0] pct;
  logic [VALUE_W-1:0] clk_hz;

  assign nib    = byte_i[3:0];
  assign pct    = VALUE_W'(PCT_BASE + int'(nib) * PCT_STEP);
  assign clk_hz = VALUE_W'(clock_base_i) + VALUE_W'(int'(nib) * CLOCK_STEP_HZ);

  always_comb begin
    dec_o           = '0;
    dec_o.kind      = KIND_NONE;
    dec_o.is_cmd    = byte_i[7];
    dec_o.eng_val   = byte_i[0];
    if (byte_i[7]) begin
      unique case (byte_i[7:4])
        GRP_STOP: begin
          if (byte_i == CMD_STOP) dec_o.kind = KIND_STOP;
          if (byte_i == CMD_FLUSH) dec_o.set_flush = 1'b1;
        end
        GRP_PITCH: begin
          dec_o.kind  = KIND_PITCH;
          dec_o.value = pct;
        end
        GRP_SPEED: begin
          dec_o.kind  = KIND_SPEED;
          dec_o.value = pct;
        end
        GRP_CLOCK: begin
          dec_o.kind  = KIND_CLOCK;
          dec_o.value = clk_hz;
        end
        GRP_ECHO: begin
          dec_o.tog_echo = (byte_i == CMD_ECHO);
        end
        GRP_ENG: begin
          dec_o.eng_wr = (byte_i[3:1] == 3'b000);
        end
        GRP_RESET: begin
          if (byte_i == CMD_RESET) begin
            dec_o.kind    = KIND_RESET;
            dec_o.clr_buf = 1'b1;
          end
        end
        default: ;
      endcase
    end else begin
      if (byte_i == CH_NUL || byte_i == CH_CR || byte_i == CH_LF) begin
        dec_o.set_flush = 1'b1;
      end else if (byte_i >= CH_SPACE) begin
        dec_o.store     = 1'b1;
        dec_o.set_flush = (byte_i == CH_DOT || byte_i == CH_BANG || byte_i == CH_QUEST);
      end
    end
  end

endmodule

// File: hw/rtl/text_byte_command_decoder_top.sv
// results: a bus byte or an idle poll gives its single result in the cycle after the transfer
// a draining poll reads each character from the text memory, a registered read, then moves
// it into the output register, one per cycle while the receiver takes them; outside drains
// one item per cycle while the output slot is free; a drain holds input until it ends
// reset: asynchronous, clears buffer level, flags, counters and clock base to 2.5 MHz
module text_byte_command_decoder_top #(
  parameter int unsigned BUFFER_DEPTH = tbcd_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [tbcd_pkg::CLK_W-1:0]   cfg_wdata_i,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         action_i,
  input  logic [7:0]                   byte_value_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [2:0]                   kind_o,
  output logic [tbcd_pkg::VALUE_W-1:0] value_o,
  output logic                         last_o,
  output logic                         echo_on_o,
  output logic                         engine_select_o,
  output logic [tbcd_pkg::COUNT_W-1:0] pending_count_o,
  output logic                         flush_pending_o,
  output logic [tbcd_pkg::TOTAL_W-1:0] char_total_o,
  output logic [tbcd_pkg::TOTAL_W-1:0] control_total_o
);
  import tbcd_pkg::*;

  // fill level needs to hold the depth itself, the address only the entries
  localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  // architectural state
  logic               state_q, state_d;
  logic [CW-1:0]      fill_q, fill_d;
  logic               flush_q, flush_d;
  logic               echo_q, echo_d;
  logic               engine_q, engine_d;
  logic [TOTAL_W-1:0] char_cnt_q, char_cnt_d;
  logic [TOTAL_W-1:0] ctrl_cnt_q, ctrl_cnt_d;
  logic [CLK_W-1:0]   clk_base_q;

  // drain sequencer
  logic [CW-1:0]      cnt_q, cnt_d;       // characters in this run
  logic [CW-1:0]      rd_idx_q, rd_idx_d; // next entry to read
  logic [CW-1:0]      mv_idx_q, mv_idx_d; // next entry to hand to the output
  logic               rd_valid_q, rd_valid_d;

  // output register
  logic               out_valid_q, out_valid_d;
  kind_e              kind_q, kind_d;
  logic [VALUE_W-1:0] value_q, value_d;
  logic               last_q, last_d;

  dec_t               dec;
  logic               out_free;
  logic               in_xfer;
  logic               is_byte;
  logic               drain_start;
  logic               mem_we;
  logic               mem_re;
  logic [7:0]         mem_rdata;
  logic               move;
  logic               run_last;

  tbcd_decode u_decode (
    .byte_i      (byte_value_i),
    .clock_base_i(clk_base_q),
    .dec_o       (dec)
  );

  tbcd_store #(
    .Depth(BUFFER_DEPTH),
    .AddrW(AW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(fill_q[AW-1:0]),
    .wdata_i(byte_value_i),
    .re_i   (mem_re),
    .raddr_i(rd_idx_q[AW-1:0]),
    .rdata_o(mem_rdata)
  );

  // output slot is free when empty or emptied at this edge
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign is_byte    = (action_i == ACT_BYTE);

  // a poll drains only with a flush pending and characters held
  assign drain_start = in_xfer && (action_i == ACT_POLL) && flush_q && (fill_q != '0);

  // text write goes to the entry the fill level points at
  assign mem_we = in_xfer && is_byte && dec.store && (fill_q < CW'(BUFFER_DEPTH));

  // two-step drain: read the memory, then move the registered data into the output
  assign move     = (state_q == ST_DRAIN) && rd_valid_q && out_free;
  assign mem_re   = (state_q == ST_DRAIN) && (rd_idx_q != cnt_q) && (!rd_valid_q || move);
  assign run_last = (mv_idx_q + CW'(1)) == cnt_q;

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    flush_d    = flush_q;
    echo_d     = echo_q;
    engine_d   = engine_q;
    char_cnt_d = char_cnt_q;
    ctrl_cnt_d = ctrl_cnt_q;
    cnt_d      = cnt_q;
    rd_idx_d   = rd_idx_q;
    mv_idx_d   = mv_idx_q;
    rd_valid_d = rd_valid_q;

    if (in_xfer) begin
      if (!is_byte) begin
        // any poll clears the flush flag; a drain also empties the buffer
        flush_d = 1'b0;
        if (drain_start) begin
          state_d    = ST_DRAIN;
          fill_d     = '0;
          cnt_d      = fill_q;
          rd_idx_d   = '0;
          mv_idx_d   = '0;
          rd_valid_d = 1'b0;
        end
      end else if (dec.is_cmd) begin
        ctrl_cnt_d = ctrl_cnt_q + TOTAL_W'(1);
        if (dec.set_flush) flush_d = 1'b1;
        if (dec.clr_buf) fill_d = '0;
        if (dec.tog_echo) echo_d = !echo_q;
        if (dec.eng_wr) engine_d = dec.eng_val;
      end else begin
        char_cnt_d = char_cnt_q + TOTAL_W'(1);
        if (dec.set_flush) flush_d = 1'b1;
        if (mem_we) fill_d = fill_q + CW'(1);
        // a printable byte that fills the buffer or finds it full requests a flush
        if (dec.store && (fill_q >= CW'(BUFFER_DEPTH - 1))) flush_d = 1'b1;
      end
    end

    if (state_q == ST_DRAIN) begin
      if (mem_re) begin
        rd_idx_d   = rd_idx_q + CW'(1);
        rd_valid_d = 1'b1;
      end else if (move) begin
        rd_valid_d = 1'b0;
      end
      if (move) begin
        mv_idx_d = mv_idx_q + CW'(1);
        if (run_last) state_d = ST_IDLE;
      end
    end
  end

  // output register loads from a transfer that answers at once or from the drain
  always_comb begin
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    value_d     = value_q;
    last_d      = last_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (in_xfer && !drain_start) begin
      out_valid_d = 1'b1;
      last_d      = 1'b1;
      if (is_byte) begin
        kind_d  = dec.kind;
        value_d = dec.value;
      end else begin
        kind_d  = KIND_NONE;
        value_d = '0;
      end
    end else if (move) begin
      out_valid_d = 1'b1;
      kind_d      = KIND_CHAR;
      value_d     = VALUE_W'(mem_rdata);
      last_d      = run_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      flush_q     <= 1'b0;
      echo_q      <= 1'b0;
      engine_q    <= 1'b0;
      char_cnt_q  <= '0;
      ctrl_cnt_q  <= '0;
      clk_base_q  <= CLOCK_BASE_RST;
      cnt_q       <= '0;
      rd_idx_q    <= '0;
      mv_idx_q    <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      flush_q     <= flush_d;
      echo_q      <= echo_d;
      engine_q    <= engine_d;
      char_cnt_q  <= char_cnt_d;
      ctrl_cnt_q  <= ctrl_cnt_d;
      if (cfg_we_i) clk_base_q <= cfg_wdata_i;
      cnt_q       <= cnt_d;
      rd_idx_q    <= rd_idx_d;
      mv_idx_q    <= mv_idx_d;
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    value_q <= value_d;
    last_q  <= last_d;
  end

  // status fields only change at an input transfer, which frees the output slot at the
  // same edge, so the live state always matches the result on display
  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign value_o         = value_q;
  assign last_o          = last_q;
  assign echo_on_o       = echo_q;
  assign engine_select_o = engine_q;
  assign pending_count_o = COUNT_W'(fill_q);
  assign flush_pending_o = flush_q;
  assign char_total_o    = char_cnt_q;
  assign control_total_o = ctrl_cnt_q;

  // fill level never passes the buffer depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(BUFFER_DEPTH))
    else $error("fill level beyond buffer depth");

  // read pointer stays between the move pointer and the run length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> (rd_idx_q >= mv_idx_q) && (rd_idx_q <= cnt_q))
    else $error("drain pointers out of order");

  // while draining the buffer reads as empty with no flush pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> (fill_q == '0) && !flush_q)
    else $error("buffer state changed during drain");

  // a run starts with a non-empty count and the first read follows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_start |=> (state_q == ST_DRAIN) && (cnt_q != '0) && mem_re)
    else $error("drain did not start reading");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

import tbcd_pkg::*;

typedef struct {
  kind_e              kind;
  logic [VALUE_W-1:0] value;
  logic               last;
  logic               echo_on;
  logic               engine_select;
  logic [COUNT_W-1:0] pending_count;
  logic               flush_pending;
  logic [TOTAL_W-1:0] char_total;
  logic [TOTAL_W-1:0] control_total;
} decoder_result_t;

class decode_board;
  logic [7:0]         text_buf [BUFFER_DEPTH_DEF];
  logic [COUNT_W-1:0] fill;
  logic               flush;
  logic               echo;
  logic               engine;
  logic [TOTAL_W-1:0] char_count;
  logic [TOTAL_W-1:0] ctrl_count;
  logic [CLK_W-1:0]   clock_base;
  decoder_result_t    results_due [$];
  int unsigned        errors;
  int unsigned        checked;

  function new();
    fill       = '0;
    flush      = 1'b0;
    echo       = 1'b0;
    engine     = 1'b0;
    char_count = '0;
    ctrl_count = '0;
    clock_base = CLOCK_BASE_RST;
    errors     = 0;
    checked    = 0;
  endfunction

  // every result carries the state as it stands after the item
  function void add_result(kind_e kind, logic [VALUE_W-1:0] value, logic last);
    decoder_result_t r;
    r.kind          = kind;
    r.value         = value;
    r.last          = last;
    r.echo_on       = echo;
    r.engine_select = engine;
    r.pending_count = fill;
    r.flush_pending = flush;
    r.char_total    = char_count;
    r.control_total = ctrl_count;
    results_due.push_back(r);
  endfunction

  function void note_input(logic act, logic [7:0] b);
    logic [3:0]         nib;
    kind_e              kind;
    logic [VALUE_W-1:0] value;
    int unsigned        n;
    int unsigned        i;
    nib   = b[3:0];
    kind  = KIND_NONE;
    value = '0;
    if (act == ACT_POLL) begin
      if (!flush || fill == 0) begin
        flush = 1'b0;
        add_result(KIND_NONE, '0, 1'b1);
        return;
      end
      // drain the whole buffer, oldest character first
      flush = 1'b0;
      n     = fill;
      fill  = '0;
      for (i = 0; i < n; i++) add_result(KIND_CHAR, VALUE_W'(text_buf[i]), i == n - 1);
      return;
    end
    if (b[7]) begin
      ctrl_count++;
      if (b == CMD_STOP) begin
        kind = KIND_STOP;
      end else if (b == CMD_FLUSH) begin
        flush = 1'b1;
      end else if (b == CMD_RESET) begin
        kind = KIND_RESET;
        fill = '0;
      end else begin
        case (b[7:4])
          GRP_PITCH: begin
            kind  = KIND_PITCH;
            value = VALUE_W'(PCT_BASE + PCT_STEP * nib);
          end
          GRP_SPEED: begin
            kind  = KIND_SPEED;
            value = VALUE_W'(PCT_BASE + PCT_STEP * nib);
          end
          GRP_CLOCK: begin
            kind  = KIND_CLOCK;
            value = VALUE_W'(clock_base + nib * CLOCK_STEP_HZ);
          end
          GRP_ECHO: begin
            if (b == CMD_ECHO) echo = ~echo;
          end
          GRP_ENG: begin
            if (b[3:1] == 3'b000) engine = b[0];
          end
          default: ;
        endcase
      end
    end else begin
      char_count++;
      if (b == CH_NUL || b == CH_CR || b == CH_LF) begin
        flush = 1'b1;
      end else if (b >= CH_SPACE) begin
        // a printable byte on a full buffer is counted and dropped
        if (fill < BUFFER_DEPTH_DEF) begin
          text_buf[fill] = b;
          fill++;
        end
        if (b == CH_DOT || b == CH_BANG || b == CH_QUEST || fill >= BUFFER_DEPTH_DEF)
          flush = 1'b1;
      end
    end
    add_result(kind, value, 1'b1);
  endfunction

  task report_mismatch(string msg);
    errors++;
    $display("mismatch at result %0d: %s", checked, msg);
  endtask

  task compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  task check_output(decoder_result_t got);
    decoder_result_t want;
    if (results_due.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind %0d value %0h", got.kind, got.value));
      return;
    end
    want = results_due.pop_front();
    checked++;
    compare_field("kind", got.kind, want.kind);
    compare_field("value", got.value, want.value);
    compare_field("last", got.last, want.last);
    compare_field("echo_on", got.echo_on, want.echo_on);
    compare_field("engine_select", got.engine_select, want.engine_select);
    compare_field("pending_count", got.pending_count, want.pending_count);
    compare_field("flush_pending", got.flush_pending, want.flush_pending);
    compare_field("char_total", got.char_total, want.char_total);
    compare_field("control_total", got.control_total, want.control_total);
  endtask
endclass

module testbench;

  // no transfer on either channel for this long means the block is stuck
  localparam int unsigned WATCHDOG_LIMIT  = 5000;
  // idle cycles after the last result before a register write or the end
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned ITEMS_PER_PHASE = 46;
  localparam int unsigned PHASES          = 5;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CLK_W-1:0]     cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 action_i;
  logic [7:0]           byte_value_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [2:0]           kind_o;
  logic [VALUE_W-1:0]   value_o;
  logic                 last_o;
  logic                 echo_on_o;
  logic                 engine_select_o;
  logic [COUNT_W-1:0]   pending_count_o;
  logic                 flush_pending_o;
  logic [TOTAL_W-1:0]   char_total_o;
  logic [TOTAL_W-1:0]   control_total_o;

  decode_board sb = new();

  // percent chances of a sender gap and of a receiver stall in a cycle
  int unsigned idle_pct     = 0;
  int unsigned stall_pct    = 0;
  int unsigned items_sent   = 0;
  int unsigned quiet_cycles = 0;

  always #2 clk_i = ~clk_i;

  text_byte_command_decoder_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .byte_value_i    (byte_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .value_o         (value_o),
    .last_o          (last_o),
    .echo_on_o       (echo_on_o),
    .engine_select_o (engine_select_o),
    .pending_count_o (pending_count_o),
    .flush_pending_o (flush_pending_o),
    .char_total_o    (char_total_o),
    .control_total_o (control_total_o)
  );

  // receiver: ready changes only at the falling edge
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // sample both channels at the rising edge; a result is registered, so it always trails its
  // item, and noting the input before checking the output is safe
  always @(posedge clk_i) begin : monitor
    decoder_result_t got;
    if (rst_ni && in_valid_i && in_ready_o) sb.note_input(action_i, byte_value_i);
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.kind          = kind_e'(kind_o);
      got.value         = value_o;
      got.last          = last_o;
      got.echo_on       = echo_on_o;
      got.engine_select = engine_select_o;
      got.pending_count = pending_count_o;
      got.flush_pending = flush_pending_o;
      got.char_total    = char_total_o;
      got.control_total = control_total_o;
      sb.check_output(got);
    end
    // watchdog on cycles with no transfer at all
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // one input transfer; entered and left at a falling edge, valid stays up
  // between back-to-back items so it is never lowered and raised in one step
  task automatic send_item(input logic act, input logic [7:0] b);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    byte_value_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(ACT_BYTE, b);
  endtask

  // the byte lane is don't-care on a poll, so it gets random junk
  task automatic send_poll();
    send_item(ACT_POLL, 8'($urandom));
  endtask

  // printable text that does not itself end a sentence
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(32, 127)); while (c == CH_DOT || c == CH_BANG || c == CH_QUEST);
    return c;
  endfunction

  function automatic logic [7:0] pick_terminator();
    case ($urandom_range(6))
      0:       return CH_DOT;
      1:       return CH_BANG;
      2:       return CH_QUEST;
      3:       return CH_CR;
      4:       return CH_LF;
      5:       return CH_NUL;
      default: return CMD_FLUSH;
    endcase
  endfunction

  // mostly known commands, the rest anything with bit 7 set
  function automatic logic [7:0] pick_command();
    case ($urandom_range(9))
      0:       return CMD_STOP;
      1:       return CMD_FLUSH;
      2:       return CMD_RESET;
      3:       return {GRP_PITCH, 4'($urandom)};
      4:       return {GRP_SPEED, 4'($urandom)};
      5:       return {GRP_CLOCK, 4'($urandom)};
      6:       return CMD_ECHO;
      7:       return {GRP_ENG, 3'b000, 1'($urandom)};
      default: return 8'($urandom_range(128, 255));
    endcase
  endfunction

  // text run up to a terminator
  task automatic send_sentence(input int unsigned len, input logic [7:0] stop_byte);
    repeat (len) send_byte(plain_char());
    send_byte(stop_byte);
  endtask

  // count above the depth overflows the buffer, then one poll drains it
  task automatic fill_buffer(input int unsigned count);
    repeat (count) send_byte(plain_char());
    send_poll();
  endtask

  // drop valid, wait for every expected result, then let the block go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.results_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_clock_base(input logic [CLK_W-1:0] base);
    settle();
    cfg_wdata_i <= base;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i      <= 1'b0;
    sb.clock_base  = base;
  endtask

  // mostly well-formed sentences followed by a poll, mixed with commands,
  // noise bytes, stray polls and now and then a buffer overflow
  task automatic random_phase(input int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_sentence($urandom_range(1, 10), pick_terminator());
        if ($urandom_range(9) != 0) send_poll();
      end else if (pick < 48) begin
        fill_buffer($urandom_range(60, 66));
      end else if (pick < 70) begin
        send_byte(pick_command());
      end else if (pick < 85) begin
        send_byte(8'($urandom));
      end else begin
        send_poll();
      end
    end
  endtask

  initial begin : stimulus
    logic [CLK_W-1:0] base_setting [PHASES];
    int unsigned      idle_setting [PHASES];
    int unsigned      stall_setting [PHASES];
    int unsigned      p;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    action_i     = ACT_BYTE;
    byte_value_i = '0;
    out_ready_i  = 1'b1;
    // clock base per phase: top and bottom of range, zero, all ones, random
    base_setting  = '{23'd8000000, 23'd1000000, '0, '1,
                      CLK_W'($urandom_range(1000000, 8000000))};
    idle_setting  = '{0, 73, 0, 33, 0};
    stall_setting = '{0, 0, 73, 33, 0};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed commands, pitch, speed and clock at nibble extremes, with the reset clock base
    send_byte(CMD_STOP);
    send_byte({GRP_PITCH, 4'h0});
    send_byte({GRP_PITCH, 4'hF});
    send_byte({GRP_SPEED, 4'h0});
    send_byte({GRP_SPEED, 4'hF});
    send_byte({GRP_CLOCK, 4'h0});
    send_byte({GRP_CLOCK, 4'hF});
    send_byte(CMD_ECHO);
    send_byte({GRP_ENG, 4'h1});
    // unknown control codes do nothing but count
    send_byte({GRP_STOP, 4'hF});
    send_byte(8'hE5);
    // poll with nothing pending, then with a flush pending on an empty buffer
    send_poll();
    send_byte(CMD_FLUSH);
    send_poll();
    // printable extremes, a dropped control character, then a drain of three
    send_byte(CH_SPACE);
    send_byte(8'h7F);
    send_byte(8'h01);
    send_byte(CH_DOT);
    send_poll();
    // reset command empties the buffer but keeps the flush request
    send_byte("A");
    send_byte(CH_CR);
    send_byte(CMD_RESET);
    send_poll();
    // the other flush characters
    send_byte("B");
    send_byte(CH_LF);
    send_byte(CH_NUL);
    send_poll();
    // full buffer: the overflow bytes are counted and dropped
    fill_buffer(BUFFER_DEPTH_DEF + 2);

    for (p = 0; p < PHASES; p++) begin
      idle_pct  = idle_setting[p];
      stall_pct = stall_setting[p];
      write_clock_base(base_setting[p]);
      random_phase(ITEMS_PER_PHASE);
    end

    settle();
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
